/* src/ffa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

	// default geometry
	localparam int NBLOCKS_DEF      = 64;
	localparam int HEADER_BYTES_DEF = 32;

	// configuration reset values
	localparam logic [26:0] MAX_REQUEST_RESET = 27'd100000000;
	localparam logic [31:0] HEAP_LIMIT_RESET  = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam logic REG_MAX_REQUEST = 1'b0;
	localparam logic REG_HEAP_LIMIT  = 1'b1;

	// request kinds
	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_FREE    = 2'd1;
	localparam logic [1:0] MODE_REALLOC = 2'd2;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_SIZE   = 3'd1,
		ST_HEAP_LIMIT = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_UNKNOWN    = 3'd4
	} status_t;

	// one block table entry
	typedef struct packed {
		logic [31:0] start;
		logic [27:0] size;
		logic        free;
	} entry_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_SCAN_START,
		OP_SCAN,
		OP_MARK_FREE,
		OP_TAKE_FIT,
		OP_APPEND,
		OP_KEEP,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t     op;
		logic    find;    // scan looks for an address, else for a fitting free block
		status_t status;  // status to report with OP_RESULT
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       size_bad;
		logic       addr_null;
		logic       scan_hit;
		logic       scan_end;
		logic       fits_old;
		logic       limit_fail;
		logic       table_full;
		logic       out_busy;
	} stat_t;

endpackage

`default_nettype wire

/* src/first_fit_block_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// First-fit heap block allocator.
// Requests enter on the s_ stream: s_tuser carries the kind (allocate, free,
// reallocate), s_tdata the size and address. One result per request leaves on
// the m_ stream with a status, the granted address and the running block and
// byte counts. max_request and heap_limit are set through cfg_we/cfg_index/
// cfg_data; the user must write them only while no request is in flight, as
// the block does not enforce it. The block table sits in one RAM with a
// registered read port; lookups walk it one entry per cycle from the oldest
// block. An allocate or free walks the table once, a reallocate that has to
// move walks it twice (first for the address, then for a fit), and requests
// that need no scan go straight to their result. One request is in work at a
// time; s_tready is high only between requests.
// The result waits in an output register; while m_tready is low the next
// request is still taken and runs up to its result, then waits for the
// register to drain.
// Reset empties the table at once (entries above the block count are never
// read) and loads the configuration defaults.
module first_fit_block_allocator import ffa_pkg::*; #(
	parameter int NBLOCKS      = NBLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,   // request_size[31:0], address[63:32]
	input  wire logic [1:0]   s_tuser,   // mode[1:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // status[2:0], result_address[34:3],
	                                     // free_blocks[45:35], free_bytes[77:46],
	                                     // total_blocks[88:78], total_bytes[120:89]
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [31:0]  cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	ffa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ffa_datapath #(
		.NBLOCKS     (NBLOCKS),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_mode  (s_tuser),
		.in_size  (s_tdata[31:0]),
		.in_addr  (s_tdata[63:32]),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// one request in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	// a block is only appended when the heap and the table have room
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_APPEND |-> !stat.limit_fail && !stat.table_full)
		else $error("append past heap limit or full table");

	// a result never overwrites one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RESULT |-> !stat.out_busy)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

/* src/ffa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// simple dual-port RAM, registered read
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* src/ffa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffa_datapath import ffa_pkg::*; #(
	parameter int NBLOCKS      = NBLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cmd_t         cmd,
	output stat_t             stat,
	input  wire logic [1:0]   in_mode,
	input  wire logic [31:0]  in_size,
	input  wire logic [31:0]  in_addr,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [31:0]  cfg_data,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata
);

	localparam int IDXW = $clog2(NBLOCKS);
	localparam int CNTW = $clog2(NBLOCKS + 1);
	localparam logic [32:0] HDR33 = 33'(HEADER_BYTES);
	localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
	localparam logic [CNTW-1:0] CNT_MAX = CNTW'(NBLOCKS);

	// configuration
	logic [26:0] max_req_q;
	logic [31:0] heap_limit_q;

	// latched request
	logic [1:0]  mode_q;
	logic [31:0] size_q;
	logic [31:0] addr_q;
	logic [32:0] total_q;

	// heap state
	logic [CNTW-1:0] entry_count_q;
	logic [CNTW-1:0] free_count_q;
	logic [31:0]     heap_break_q;
	logic [31:0]     free_byte_sum_q;
	logic [31:0]     byte_sum_q;

	// scan pointer and compare stage
	logic [CNTW-1:0] idx_q;
	logic            chk_valid_s1;
	logic [IDXW-1:0] chk_idx_s1;

	// block found by address, block found by first fit
	logic [IDXW-1:0] hit_idx_q;
	logic [31:0]     hit_start_q;
	logic [27:0]     hit_size_q;
	logic            hit_free_q;
	logic [IDXW-1:0] fit_idx_q;
	logic [31:0]     fit_start_q;
	logic [27:0]     fit_size_q;

	logic [31:0]  res_addr_q;
	logic         out_valid_q;
	logic [127:0] out_data_q;

	// table memory
	logic            ram_we;
	logic [IDXW-1:0] ram_waddr;
	entry_t          ram_wdata;
	entry_t          ram_rdata;

	ffa_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NBLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q[IDXW-1:0]),
		.rdata(ram_rdata)
	);

	logic        idx_lt;
	logic        match_find;
	logic        match_fit;
	logic        scan_hit;
	logic [33:0] new_break;

	assign idx_lt     = idx_q < entry_count_q;
	assign match_find = ({1'b0, ram_rdata.start} + HDR33) == {1'b0, addr_q};
	assign match_fit  = ram_rdata.free && (total_q <= {5'b0, ram_rdata.size});
	assign scan_hit   = chk_valid_s1 && (cmd.find ? match_find : match_fit);
	assign new_break  = {2'b0, heap_break_q} + {1'b0, total_q};

	always_comb begin
		stat.mode       = mode_q;
		stat.size_bad   = (size_q == 32'd0) || (size_q > {5'b0, max_req_q});
		stat.addr_null  = addr_q == 32'd0;
		stat.scan_hit   = scan_hit;
		stat.scan_end   = !chk_valid_s1 && !idx_lt;
		stat.fits_old   = total_q <= {5'b0, hit_size_q};
		stat.limit_fail = new_break > {2'b0, heap_limit_q};
		stat.table_full = entry_count_q >= CNT_MAX;
		stat.out_busy   = out_valid_q && !m_tready;
	end

	// table write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		ram_wdata = '{start: hit_start_q, size: hit_size_q, free: 1'b1};
		case (cmd.op)
			OP_MARK_FREE: begin
				ram_we = 1'b1;
			end
			OP_TAKE_FIT: begin
				ram_we    = 1'b1;
				ram_waddr = fit_idx_q;
				ram_wdata = '{start: fit_start_q, size: fit_size_q, free: 1'b0};
			end
			OP_APPEND: begin
				ram_we    = 1'b1;
				ram_waddr = entry_count_q[IDXW-1:0];
				ram_wdata = '{start: heap_break_q, size: total_q[27:0], free: 1'b0};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_req_q    <= MAX_REQUEST_RESET;
			heap_limit_q <= HEAP_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_REQUEST: max_req_q    <= cfg_data[26:0];
				REG_HEAP_LIMIT:  heap_limit_q <= cfg_data;
				default:         max_req_q    <= max_req_q;
			endcase
		end
	end

	// control state: counters, scan pointer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q   <= '0;
			free_count_q    <= '0;
			heap_break_q    <= '0;
			free_byte_sum_q <= '0;
			byte_sum_q      <= '0;
			idx_q           <= '0;
			chk_valid_s1    <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			// a new result may load in the cycle the waiting one drains
			if (cmd.op == OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_SCAN_START: begin
					idx_q        <= '0;
					chk_valid_s1 <= 1'b0;
				end
				OP_SCAN: begin
					chk_valid_s1 <= idx_lt;
					if (idx_lt) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				OP_MARK_FREE: begin
					if (!hit_free_q) begin
						free_count_q    <= free_count_q + 1'b1;
						free_byte_sum_q <= free_byte_sum_q + (32'(hit_size_q) - HDR32);
					end
				end
				OP_TAKE_FIT: begin
					free_count_q    <= free_count_q - 1'b1;
					free_byte_sum_q <= free_byte_sum_q - (32'(fit_size_q) - HDR32);
				end
				OP_APPEND: begin
					entry_count_q <= entry_count_q + 1'b1;
					byte_sum_q    <= byte_sum_q + size_q;
					heap_break_q  <= new_break[31:0];
				end
				default: begin
					chk_valid_s1 <= chk_valid_s1;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == OP_SCAN) begin
			chk_idx_s1 <= idx_q[IDXW-1:0];
		end
		if (cmd.op == OP_SCAN && scan_hit) begin
			if (cmd.find) begin
				hit_idx_q   <= chk_idx_s1;
				hit_start_q <= ram_rdata.start;
				hit_size_q  <= ram_rdata.size;
				hit_free_q  <= ram_rdata.free;
			end else begin
				fit_idx_q   <= chk_idx_s1;
				fit_start_q <= ram_rdata.start;
				fit_size_q  <= ram_rdata.size;
			end
		end
		case (cmd.op)
			OP_LATCH: begin
				mode_q     <= in_mode;
				size_q     <= in_size;
				addr_q     <= in_addr;
				total_q    <= {1'b0, in_size} + HDR33;
				res_addr_q <= '0;
			end
			OP_TAKE_FIT: res_addr_q <= fit_start_q + HDR32;
			OP_APPEND:   res_addr_q <= heap_break_q + HDR32;
			OP_KEEP:     res_addr_q <= addr_q;
			OP_RESULT: begin
				out_data_q <= {7'b0, byte_sum_q, 11'(entry_count_q), free_byte_sum_q,
				               11'(free_count_q), res_addr_q, cmd.status};
			end
			default: begin
				res_addr_q <= res_addr_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

/* src/ffa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffa_ctrl import ffa_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FIND,
		S_FOUND,
		S_FIT,
		S_TAKE,
		S_GROW,
		S_MARK,
		S_RESP
	} state_t;

	state_t  state_q;
	status_t status_q;
	logic    old_q;     // a reallocated block must be released after the new grant

	logic go_find;
	logic go_fit;

	// request decode
	always_comb begin
		go_find = 1'b0;
		go_fit  = 1'b0;
		case (stat.mode)
			MODE_ALLOC: go_fit = !stat.size_bad;
			MODE_FREE:  go_find = !stat.addr_null;
			MODE_REALLOC: begin
				go_find = !stat.size_bad && !stat.addr_null;
				go_fit  = !stat.size_bad && stat.addr_null;
			end
			default: go_fit = 1'b0;
		endcase
	end

	assign s_tready = state_q == S_IDLE;

	// datapath commands
	always_comb begin
		cmd.op     = OP_NONE;
		cmd.find   = 1'b0;
		cmd.status = status_q;
		case (state_q)
			S_IDLE:   cmd.op = s_tvalid ? OP_LATCH : OP_NONE;
			S_DECODE: begin
				cmd.op   = (go_find || go_fit) ? OP_SCAN_START : OP_NONE;
				cmd.find = go_find;
			end
			S_FIND: begin
				cmd.op   = OP_SCAN;
				cmd.find = 1'b1;
			end
			S_FOUND: begin
				if (stat.mode == MODE_FREE) begin
					cmd.op = OP_MARK_FREE;
				end else if (stat.fits_old) begin
					cmd.op = OP_KEEP;
				end else begin
					cmd.op = OP_SCAN_START;
				end
			end
			S_FIT:  cmd.op = OP_SCAN;
			S_TAKE: cmd.op = OP_TAKE_FIT;
			S_GROW: cmd.op = (stat.limit_fail || stat.table_full) ? OP_NONE : OP_APPEND;
			S_MARK: cmd.op = OP_MARK_FREE;
			S_RESP: cmd.op = stat.out_busy ? OP_NONE : OP_RESULT;
			default: cmd.op = OP_NONE;
		endcase
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
			old_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					old_q <= 1'b0;
					if (go_find) begin
						status_q <= ST_OK;
						state_q  <= S_FIND;
					end else if (go_fit) begin
						status_q <= ST_OK;
						state_q  <= S_FIT;
					end else begin
						if ((stat.mode == MODE_ALLOC || stat.mode == MODE_REALLOC)
						    && stat.size_bad) begin
							status_q <= ST_BAD_SIZE;
						end else begin
							status_q <= ST_OK;
						end
						state_q <= S_RESP;
					end
				end
				S_FIND: begin
					if (stat.scan_hit) begin
						state_q <= S_FOUND;
					end else if (stat.scan_end) begin
						status_q <= ST_UNKNOWN;
						state_q  <= S_RESP;
					end
				end
				S_FOUND: begin
					if (stat.mode == MODE_FREE || stat.fits_old) begin
						state_q <= S_RESP;
					end else begin
						old_q   <= 1'b1;
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					if (stat.scan_hit) begin
						state_q <= S_TAKE;
					end else if (stat.scan_end) begin
						state_q <= S_GROW;
					end
				end
				S_TAKE: state_q <= old_q ? S_MARK : S_RESP;
				S_GROW: begin
					if (stat.limit_fail) begin
						status_q <= ST_HEAP_LIMIT;
						state_q  <= S_RESP;
					end else if (stat.table_full) begin
						status_q <= ST_TABLE_FULL;
						state_q  <= S_RESP;
					end else begin
						state_q <= old_q ? S_MARK : S_RESP;
					end
				end
				S_MARK: state_q <= S_RESP;
				S_RESP: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* test/tb_first_fit_block_allocator.sv */
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
	import ffa_pkg::*;

	localparam int NBLK = NBLOCKS_DEF;
	localparam int HDR = HEADER_BYTES_DEF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	// reply layout on m_tdata, lowest field last
	typedef struct packed {
		logic [6:0]  zero_fill;
		logic [31:0] total_bytes;
		logic [10:0] total_blocks;
		logic [31:0] free_bytes;
		logic [10:0] free_blocks;
		logic [31:0] addr;
		status_t     status;
	} heap_reply_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;   // request_size[31:0], address[63:32]
	logic [1:0]   s_tuser = '0;   // mode[1:0]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;        // status, result_address, free_blocks, free_bytes,
	                              // total_blocks, total_bytes
	logic         cfg_we = 1'b0;
	logic         cfg_index = REG_MAX_REQUEST;
	logic [31:0]  cfg_data = '0;

	// shadow of the allocator
	logic [31:0] blk_start [NBLK];
	logic [27:0] blk_size [NBLK];
	bit          blk_free [NBLK];
	int unsigned blk_count = 0;
	int unsigned nfree = 0;
	logic [31:0] brk = '0;
	logic [31:0] free_sum = '0;
	logic [31:0] total_sum = '0;
	logic [26:0] max_req = MAX_REQUEST_RESET;
	logic [31:0] heap_lim = HEAP_LIMIT_RESET;

	heap_reply_t replies_due[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          gaps_enabled = 1'b1;

	first_fit_block_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] payload_bytes(int unsigned i);
		return {4'b0, blk_size[i]} - HDR;
	endfunction

	// index of the block owning this payload offset, -1 if none
	function automatic int find_block(logic [31:0] addr);
		int i;
		for (i = 0; i < blk_count; i++)
			if (blk_start[i] + HDR == addr)
				return i;
		return -1;
	endfunction

	function automatic void release_block(int unsigned i);
		if (!blk_free[i]) begin
			blk_free[i] = 1'b1;
			nfree++;
			free_sum = free_sum + payload_bytes(i);
		end
	endfunction

	// first fit over the table, else grow at the break
	function automatic status_t claim_block(logic [31:0] size, output logic [31:0] granted);
		logic [32:0] need;
		logic [32:0] new_brk;
		int i;
		granted = '0;
		if (size == 0 || size > max_req)
			return ST_BAD_SIZE;
		need = size + HDR;
		for (i = 0; i < blk_count; i++) begin
			if (blk_free[i] && need <= blk_size[i]) begin
				blk_free[i] = 1'b0;
				nfree--;
				free_sum = free_sum - payload_bytes(i);
				granted = blk_start[i] + HDR;
				return ST_OK;
			end
		end
		new_brk = {1'b0, brk} + need;
		if (new_brk > {1'b0, heap_lim})
			return ST_HEAP_LIMIT;
		if (blk_count >= NBLK)
			return ST_TABLE_FULL;
		blk_start[blk_count] = brk;
		blk_size[blk_count] = need[27:0];
		blk_free[blk_count] = 1'b0;
		blk_count++;
		total_sum = total_sum + size;
		granted = brk + HDR;
		brk = new_brk[31:0];
		return ST_OK;
	endfunction

	function automatic heap_reply_t apply_heap_request(logic [1:0] mode, logic [31:0] size,
			logic [31:0] addr);
		heap_reply_t res;
		logic [31:0] granted;
		int slot;
		res = '0;
		res.status = ST_OK;
		granted = '0;
		case (mode)
			MODE_ALLOC: begin
				res.status = claim_block(size, granted);
			end
			MODE_FREE: begin
				if (addr != 0) begin
					slot = find_block(addr);
					if (slot < 0)
						res.status = ST_UNKNOWN;
					else
						release_block(slot);
				end
			end
			MODE_REALLOC: begin
				if (size == 0 || size > max_req) begin
					res.status = ST_BAD_SIZE;
				end else if (addr == 0) begin
					res.status = claim_block(size, granted);
				end else begin
					slot = find_block(addr);
					if (slot < 0) begin
						res.status = ST_UNKNOWN;
					end else if (size <= payload_bytes(slot)) begin
						granted = addr;
					end else begin
						res.status = claim_block(size, granted);
						// old block goes free only once the move succeeded
						if (res.status == ST_OK)
							release_block(slot);
					end
				end
			end
			default: ;
		endcase
		res.addr = granted;
		res.free_blocks = nfree[10:0];
		res.free_bytes = free_sum;
		res.total_blocks = blk_count[10:0];
		res.total_bytes = total_sum;
		return res;
	endfunction

	// break plus some headroom, saturated at the top of the address space
	function automatic logic [31:0] heap_headroom(int unsigned extra);
		longint unsigned sum;
		sum = longint'(brk) + extra;
		return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	function automatic logic [31:0] pick_size();
		int unsigned r;
		int unsigned cap;
		r = $urandom_range(0, 19);
		cap = (max_req < 27'd600) ? max_req : 600;
		case (r)
			0: return 32'd0;
			1: return {5'b0, max_req} + $urandom_range(1, 4096);
			2: return $urandom;
			3: return {5'b0, max_req};
			4: return $urandom_range(1, max_req);
			default: return $urandom_range(1, cap);
		endcase
	endfunction

	// mostly live payload offsets, some null, stray or off by one
	function automatic logic [31:0] pick_address();
		int unsigned r;
		int unsigned k;
		r = $urandom_range(0, 19);
		if (blk_count == 0 || r == 0)
			return 32'd0;
		if (r < 3)
			return $urandom;
		k = $urandom_range(0, blk_count - 1);
		if (r == 3)
			return blk_start[k] + HDR + 1;
		return blk_start[k] + HDR;
	endfunction

	// one request over the slave stream; valid stays up for back-to-back requests
	task automatic send_request(input logic [1:0] mode, input logic [31:0] size,
			input logic [31:0] addr, output heap_reply_t reply);
		if (gaps_enabled && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {addr, size};
		do @(posedge clk); while (!s_tready);
		reply = apply_heap_request(mode, size, addr);
		replies_due.push_back(reply);
	endtask

	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (replies_due.size() != 0);
	endtask

	// both registers, written back to back while nothing is in flight
	task automatic set_limits(input logic [31:0] max_word, input logic [31:0] limit_word);
		wait_for_replies();
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_REQUEST;
		cfg_data <= max_word;
		@(posedge clk);
		cfg_index <= REG_HEAP_LIMIT;
		cfg_data <= limit_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		max_req = max_word[26:0];
		heap_lim = limit_word;
	endtask

	task automatic send_random_request();
		heap_reply_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			send_request(MODE_UNUSED, $urandom, $urandom, r);
		else if (pick < 40)
			send_request(MODE_ALLOC, pick_size(), $urandom, r);
		else if (pick < 70)
			send_request(MODE_FREE, $urandom, pick_address(), r);
		else
			send_request(MODE_REALLOC, pick_size(), pick_address(), r);
	endtask

	task automatic test_directed_cases();
		heap_reply_t r;
		heap_reply_t first;
		heap_reply_t second;
		heap_reply_t moved;
		send_request(MODE_FREE, 32'd0, 32'd0, r);                 // null free
		send_request(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, r);
		send_request(MODE_ALLOC, 32'd0, 32'd0, r);                // zero size
		send_request(MODE_ALLOC, {5'b0, MAX_REQUEST_RESET} + 1, 32'd0, r);
		send_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0, r);
		send_request(MODE_ALLOC, 32'd100, 32'd0, first);
		send_request(MODE_ALLOC, 32'd1, 32'd0, second);
		send_request(MODE_ALLOC, {5'b0, MAX_REQUEST_RESET}, 32'd0, r);
		send_request(MODE_FREE, 32'd0, first.addr + 1, r);        // unknown address
		send_request(MODE_FREE, 32'd0, first.addr, r);
		send_request(MODE_FREE, 32'd0, first.addr, r);            // double free
		send_request(MODE_ALLOC, 32'd100, 32'd0, r);              // exact reuse
		send_request(MODE_REALLOC, 32'd10, 32'd0, r);             // null realloc
		send_request(MODE_REALLOC, 32'd1, second.addr, r);        // fits in place
		send_request(MODE_REALLOC, 32'd0, 32'd999, r);            // size checked first
		send_request(MODE_REALLOC, 32'd5, 32'd999, r);
		send_request(MODE_REALLOC, 32'd500, second.addr, moved);  // moves, old freed
		send_request(MODE_REALLOC, 32'd1, second.addr, r);        // fits though free
		send_request(MODE_REALLOC, 32'hFFFF_FFFF, moved.addr, r);
		send_request(MODE_FREE, 32'd0, 32'hFFFF_FFFF, r);
		send_request(MODE_ALLOC, 32'd101, 32'd0, r);              // free block too small
		send_request(MODE_ALLOC, 32'd1, 32'd0, r);                // takes the one free block
	endtask

	task automatic test_limit_registers();
		heap_reply_t r;
		heap_reply_t small_blk;
		// max of one with junk above the register width; heap ends exactly one block out
		set_limits(32'hF800_0001, heap_headroom(HDR + 1));
		send_request(MODE_ALLOC, 32'd2, 32'd0, r);
		send_request(MODE_ALLOC, 32'd1, 32'd0, small_blk);
		send_request(MODE_ALLOC, 32'd1, 32'd0, r);
		send_request(MODE_REALLOC, 32'd1, small_blk.addr, r);
		// no room to grow: a move fails and the old block stays
		set_limits(32'h07FF_FFFF, brk);
		send_request(MODE_REALLOC, 32'd1000, small_blk.addr, r);
		send_request(MODE_FREE, 32'd0, small_blk.addr, r);
		set_limits(32'h07FF_FFFF, 32'd0);
		send_request(MODE_ALLOC, 32'd1, 32'd0, r);
		send_request(MODE_ALLOC, 32'd1, 32'd0, r);
		send_request(MODE_REALLOC, 32'h07FF_FFFF, 32'd0, r);
	endtask

	task automatic random_phase(input logic [31:0] max_word, input logic [31:0] limit_word,
			input int unsigned count);
		int unsigned n;
		set_limits(max_word, limit_word);
		for (n = 0; n < count; n++) begin
			// now and then hold off until the allocator has answered everything
			if ($urandom_range(0, 59) == 0)
				wait_for_replies();
			send_random_request();
		end
	endtask

	task automatic test_table_full();
		heap_reply_t r;
		int unsigned tries;
		set_limits(32'h0000_1000, 32'hFFFF_FFFF);
		// use up free blocks, then append until the table is full
		tries = 0;
		while ((blk_count < NBLK || nfree != 0) && tries < 200) begin
			send_request(MODE_ALLOC, 32'd1, 32'd0, r);
			tries++;
		end
		send_request(MODE_ALLOC, 32'd2048, 32'd0, r);
		send_request(MODE_REALLOC, 32'd16, 32'd0, r);
		// heap limit is reported ahead of table full
		set_limits(32'h0000_1000, 32'd0);
		send_request(MODE_ALLOC, 32'd1, 32'd0, r);
		send_request(MODE_FREE, 32'd0, blk_start[blk_count - 1] + HDR, r);
		send_request(MODE_ALLOC, 32'd1, 32'd0, r);
	endtask

	// result side: random stalls, then steady once the gaps are switched off
	initial begin
		forever begin
			@(posedge clk);
			if (gaps_enabled && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// every reply is checked against the oldest predicted one
	initial begin
		heap_reply_t got;
		heap_reply_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = heap_reply_t'(m_tdata);
				if (replies_due.size() == 0) begin
					$display("%0t: reply with no request pending, expected none, actual 0x%0h",
						$time, m_tdata);
					mismatch_count++;
				end else begin
					want = replies_due.pop_front();
					compare_field("status", want.status, got.status);
					compare_field("result_address", want.addr, got.addr);
					compare_field("free_blocks", want.free_blocks, got.free_blocks);
					compare_field("free_bytes", want.free_bytes, got.free_bytes);
					compare_field("total_blocks", want.total_blocks, got.total_blocks);
					compare_field("total_bytes", want.total_bytes, got.total_bytes);
				end
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_limit_registers();
		random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);
		random_phase(32'd1000, heap_headroom(20000), 100);
		random_phase(32'd1, 32'hFFFF_FFFF, 60);
		random_phase($urandom_range(1, 32'h07FF_FFFF), $urandom, 100);
		test_table_full();
		random_phase(32'd600, 32'hFFFF_FFFF, 120);
		random_phase(32'd256, 32'd0, 60);
		gaps_enabled = 1'b0;
		random_phase(32'd4096, 32'hFFFF_FFFF, 160);
		wait_for_replies();
		// catch any stray reply after the last one
		repeat (300) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
